// File: rtl/bmf_pkg.sv
package bmf_pkg;

	localparam int unsigned MAX_WIDTH  = 4096;
	localparam int unsigned MAX_HEIGHT = 4096;
	localparam int unsigned COL_W      = $clog2(MAX_WIDTH);
	localparam int unsigned ROW_W      = $clog2(MAX_HEIGHT);
	localparam int unsigned CFG_W      = 13;
	localparam int unsigned IDX_W      = 2;
	localparam int unsigned PIX_W      = 8;

	localparam logic [IDX_W-1:0] REG_WIDTH  = IDX_W'(0);
	localparam logic [IDX_W-1:0] REG_HEIGHT = IDX_W'(1);

	localparam logic [CFG_W-1:0] SIZE_RESET = CFG_W'(256);

	// window columns that survive a shift, bit index is row*3+col
	localparam logic [8:0] WIN_KEEP = 9'h0DB;

	typedef logic [COL_W-1:0] col_t;
	typedef logic [ROW_W-1:0] row_t;
	typedef logic [1:0]       store_word_t;

	typedef struct packed {
		col_t col_last;
		row_t row_last;
	} geom_t;

	typedef struct packed {
		logic        rd_en;
		col_t        rd_addr;
		logic        wr_en;
		col_t        wr_addr;
		store_word_t wr_data;
	} store_req_t;

	typedef struct packed {
		logic [8:0] win;
		row_t       row;
		col_t       col;
		logic [3:0] pend;
	} item_t;

	function automatic logic [CFG_W-1:0] size_last(input logic [CFG_W-1:0] v,
		input logic [CFG_W-1:0] lim);
		logic [CFG_W-1:0] r;
		if (v == '0) begin
			r = '0;
		end else if (v > lim) begin
			r = lim - CFG_W'(1);
		end else begin
			r = v - CFG_W'(1);
		end
		return r;
	endfunction

	// returns {new value, old value}
	function automatic logic [1:0] vote(input logic [8:0] win, input logic row_hi,
		input logic col_hi, input logic top_ok, input logic bot_ok,
		input logic left_ok, input logic right_ok);
		int         cr;
		int         cc;
		int         gr;
		int         gc;
		logic       rv;
		logic       cv;
		logic [3:0] cnt;
		logic [3:0] white;
		logic       newv;
		cr    = row_hi ? 2 : 1;
		cc    = col_hi ? 2 : 1;
		cnt   = '0;
		white = '0;
		for (int dr = 0; dr < 3; dr++) begin
			for (int dc = 0; dc < 3; dc++) begin
				gr = cr - 1 + dr;
				gc = cc - 1 + dc;
				rv = (dr == 0) ? top_ok : ((dr == 2) ? bot_ok : 1'b1);
				cv = (dc == 0) ? left_ok : ((dc == 2) ? right_ok : 1'b1);
				if (rv && cv && gr <= 2 && gc <= 2) begin
					cnt   = cnt + 4'd1;
					white = white + {3'b000, win[gr*3+gc]};
				end
			end
		end
		newv = ((cnt - white) > white) ? 1'b0 : 1'b1;
		return {newv, win[cr*3+cc]};
	endfunction

endpackage

// File: rtl/bmf_row_store.sv
module bmf_row_store (
	input  logic                 clk,
	input  bmf_pkg::store_req_t  req,
	output bmf_pkg::store_word_t rd_data
);
	import bmf_pkg::*;

	// bit 1 holds row r-2, bit 0 holds row r-1
	store_word_t mem [MAX_WIDTH];
	store_word_t rd_q;

	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem[req.wr_addr] <= req.wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (req.rd_en) begin
			rd_q <= mem[req.rd_addr];
		end
	end

	assign rd_data = rd_q;

endmodule

// File: rtl/bmf_front.sv
module bmf_front (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       pix_valid,
	output logic                       pix_stall,
	input  logic [bmf_pkg::PIX_W-1:0]  pixel_value,
	input  logic                       cfg_wr_en,
	input  logic [bmf_pkg::IDX_W-1:0]  cfg_index,
	input  logic [bmf_pkg::CFG_W-1:0]  cfg_data,
	input  logic                       s2_free,
	output bmf_pkg::store_req_t        store_req,
	input  bmf_pkg::store_word_t       store_rd,
	output bmf_pkg::geom_t             geom,
	output bmf_pkg::item_t             item,
	output logic                       item_load,
	output logic                       restart
);
	import bmf_pkg::*;

	logic             accept;
	logic             adv1;
	logic [CFG_W-1:0] width_last;
	logic [CFG_W-1:0] height_last;

	col_t        col_last_q;
	row_t        row_last_q;
	col_t        col_q;
	row_t        row_q;
	logic [8:0]  win_q;
	logic [8:0]  win_next;

	logic        v_s1;
	logic        pix_s1;
	col_t        col_s1;
	row_t        row_s1;
	logic        fresh_q;
	logic        fwd_q;
	store_word_t fwd_d_q;
	store_word_t hold_q;
	store_word_t eff;
	logic [3:0]  mask;

	assign restart     = cfg_wr_en && (cfg_index == REG_WIDTH || cfg_index == REG_HEIGHT);
	assign width_last  = size_last(cfg_data, CFG_W'(MAX_WIDTH));
	assign height_last = size_last(cfg_data, CFG_W'(MAX_HEIGHT));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_last_q <= COL_W'(SIZE_RESET - CFG_W'(1));
			row_last_q <= ROW_W'(SIZE_RESET - CFG_W'(1));
		end else if (cfg_wr_en) begin
			if (cfg_index == REG_WIDTH) begin
				col_last_q <= width_last[COL_W-1:0];
			end
			if (cfg_index == REG_HEIGHT) begin
				row_last_q <= height_last[ROW_W-1:0];
			end
		end
	end

	assign geom.col_last = col_last_q;
	assign geom.row_last = row_last_q;

	// results due: (r-1,c-1), (r-1,c), (r,c-1), (r,c)
	always_comb begin
		mask[0] = (row_s1 != '0) && (col_s1 != '0);
		mask[1] = (row_s1 != '0) && (col_s1 == col_last_q);
		mask[2] = (row_s1 == row_last_q) && (col_s1 != '0);
		mask[3] = (row_s1 == row_last_q) && (col_s1 == col_last_q);
	end

	assign adv1      = v_s1 && (mask == '0 || s2_free);
	assign pix_stall = v_s1 && !adv1;
	assign accept    = pix_valid && !pix_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (restart) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (col_q == col_last_q) begin
				col_q <= '0;
				row_q <= (row_q == row_last_q) ? '0 : row_q + ROW_W'(1);
			end else begin
				col_q <= col_q + COL_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			fresh_q <= 1'b0;
			fwd_q   <= 1'b0;
		end else begin
			v_s1    <= accept || (v_s1 && !adv1);
			fresh_q <= accept;
			fwd_q   <= adv1 && (col_s1 == col_q);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pix_s1 <= (pixel_value != '0);
			col_s1 <= col_q;
			row_s1 <= row_q;
		end
		fwd_d_q <= {eff[0], pix_s1};
		hold_q  <= eff;
	end

	// bypass the row store when the entry read was written at the same edge
	assign eff = fresh_q ? (fwd_q ? fwd_d_q : store_rd) : hold_q;

	assign win_next = ((win_q >> 1) & WIN_KEEP) | {pix_s1, 2'b00, eff[0], 2'b00, eff[1], 2'b00};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q <= '0;
		end else if (restart) begin
			win_q <= '0;
		end else if (adv1) begin
			win_q <= win_next;
		end
	end

	always_comb begin
		store_req.rd_en   = accept;
		store_req.rd_addr = col_q;
		store_req.wr_en   = adv1;
		store_req.wr_addr = col_s1;
		store_req.wr_data = {eff[0], pix_s1};
	end

	assign item.win  = win_next;
	assign item.row  = row_s1;
	assign item.col  = col_s1;
	assign item.pend = mask;
	assign item_load = adv1 && (mask != '0);

endmodule

// File: rtl/bmf_emit.sv
module bmf_emit (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 restart,
	input  bmf_pkg::geom_t       geom,
	input  bmf_pkg::item_t       item,
	input  logic                 item_load,
	output logic                 s2_free,
	output logic                 res_valid,
	input  logic                 res_stall,
	output logic                 filtered_pixel,
	output bmf_pkg::col_t        out_col,
	output bmf_pkg::row_t        out_row,
	output logic                 pixel_changed,
	output logic                 frame_changed,
	output logic                 last_of_run,
	output logic                 last_of_frame
);
	import bmf_pkg::*;

	logic       v_s2;
	logic [8:0] win_s2;
	row_t       row_s2;
	col_t       col_s2;
	logic [3:0] pend_s2;

	logic [1:0] k;
	logic [3:0] rem;
	row_t       ar;
	col_t       ac;
	logic [1:0] vr;
	logic       changed;
	logic       frame_chg;
	logic       at_end;
	logic       fire;
	logic       flag_q;

	logic res_valid_q;
	logic res_pix_q;
	col_t res_col_q;
	row_t res_row_q;
	logic res_chg_q;
	logic res_frame_q;
	logic res_run_q;
	logic res_end_q;

	always_comb begin
		if (pend_s2[0]) begin
			k = 2'd0;
		end else if (pend_s2[1]) begin
			k = 2'd1;
		end else if (pend_s2[2]) begin
			k = 2'd2;
		end else begin
			k = 2'd3;
		end
		rem = pend_s2 & ~(4'b0001 << k);
		ar  = k[1] ? row_s2 : row_s2 - ROW_W'(1);
		ac  = k[0] ? col_s2 : col_s2 - COL_W'(1);
		vr  = vote(win_s2, k[1], k[0], ar != '0, ar != geom.row_last,
			ac != '0, ac != geom.col_last);
		changed   = vr[1] ^ vr[0];
		frame_chg = flag_q | changed;
		at_end    = (ar == geom.row_last) && (ac == geom.col_last);
	end

	assign fire    = v_s2 && (!res_valid_q || !res_stall);
	assign s2_free = !v_s2 || (fire && rem == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (item_load) begin
			v_s2 <= 1'b1;
		end else if (fire && rem == '0) begin
			v_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (item_load) begin
			win_s2  <= item.win;
			row_s2  <= item.row;
			col_s2  <= item.col;
			pend_s2 <= item.pend;
		end else if (fire) begin
			pend_s2 <= rem;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flag_q <= 1'b0;
		end else if (restart) begin
			flag_q <= 1'b0;
		end else if (fire) begin
			flag_q <= at_end ? 1'b0 : frame_chg;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (fire) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			res_pix_q   <= vr[1];
			res_col_q   <= ac;
			res_row_q   <= ar;
			res_chg_q   <= changed;
			res_frame_q <= frame_chg;
			res_run_q   <= (rem == '0);
			res_end_q   <= at_end;
		end
	end

	assign res_valid      = res_valid_q;
	assign filtered_pixel = res_pix_q;
	assign out_col        = res_col_q;
	assign out_row        = res_row_q;
	assign pixel_changed  = res_chg_q;
	assign frame_changed  = res_frame_q;
	assign last_of_run    = res_run_q;
	assign last_of_frame  = res_end_q;

endmodule

// File: rtl/binary_majority_filter_3x3_top.sv
// channel   | handshake            | payload
// pixels    | pix_valid, pix_stall | pixel_value
// results   | res_valid, res_stall | filtered_pixel, out_col, out_row, pixel_changed,
//           |                      | frame_changed, last_of_run, last_of_frame
// config    | cfg_wr_en            | cfg_index, cfg_data
//
// one pixel per cycle while each pixel gives at most one result and res_stall is low; a pixel
// that gives n results holds the one-result-a-cycle emitter (while res_stall is low) until the
// last of them fires, so the next pixel with results waits in s1 and pix_stall can stay high
// first result of a pixel passes s1 (row store read), then s2, then the result register (emit)
// reset clears counters, window and flags; the row store is not cleared
// res_stall backs up through the emitter and s1 into pix_stall in the same cycle
module binary_majority_filter_3x3_top (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      pix_valid,
	output logic                      pix_stall,
	input  logic [bmf_pkg::PIX_W-1:0] pixel_value,
	input  logic                      cfg_wr_en,
	input  logic [bmf_pkg::IDX_W-1:0] cfg_index,
	input  logic [bmf_pkg::CFG_W-1:0] cfg_data,
	output logic                      res_valid,
	input  logic                      res_stall,
	output logic                      filtered_pixel,
	output logic [bmf_pkg::COL_W-1:0] out_col,
	output logic [bmf_pkg::ROW_W-1:0] out_row,
	output logic                      pixel_changed,
	output logic                      frame_changed,
	output logic                      last_of_run,
	output logic                      last_of_frame
);
	import bmf_pkg::*;

	store_req_t  store_req;
	store_word_t store_rd;
	geom_t       geom;
	item_t       item;
	logic        item_load;
	logic        s2_free;
	logic        restart;

	bmf_row_store u_store (
		.clk     (clk),
		.req     (store_req),
		.rd_data (store_rd)
	);

	bmf_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.pix_valid   (pix_valid),
		.pix_stall   (pix_stall),
		.pixel_value (pixel_value),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.s2_free     (s2_free),
		.store_req   (store_req),
		.store_rd    (store_rd),
		.geom        (geom),
		.item        (item),
		.item_load   (item_load),
		.restart     (restart)
	);

	bmf_emit u_emit (
		.clk            (clk),
		.arst_n         (arst_n),
		.restart        (restart),
		.geom           (geom),
		.item           (item),
		.item_load      (item_load),
		.s2_free        (s2_free),
		.res_valid      (res_valid),
		.res_stall      (res_stall),
		.filtered_pixel (filtered_pixel),
		.out_col        (out_col),
		.out_row        (out_row),
		.pixel_changed  (pixel_changed),
		.frame_changed  (frame_changed),
		.last_of_run    (last_of_run),
		.last_of_frame  (last_of_frame)
	);

endmodule

// File: rtl/bmf_checker.sv
module bmf_checker (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      res_valid,
	input logic                      res_stall,
	input logic                      filtered_pixel,
	input logic [bmf_pkg::COL_W-1:0] out_col,
	input logic [bmf_pkg::ROW_W-1:0] out_row,
	input logic                      pixel_changed,
	input logic                      frame_changed,
	input logic                      last_of_run,
	input logic                      last_of_frame
);
	import bmf_pkg::*;

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(out_col) && $stable(out_row)
			&& $stable(filtered_pixel) && $stable(last_of_run))
		else $error("stalled result beat changed");

	a_end_is_run_end: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && last_of_frame |-> last_of_run)
		else $error("frame end result not last of its run");

	a_change_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && pixel_changed |-> frame_changed)
		else $error("changed pixel without frame change flag");

	a_reset_quiet: assert property (@(posedge clk)
		!arst_n |=> !res_valid)
		else $error("result valid during reset");

endmodule

bind binary_majority_filter_3x3_top bmf_checker u_bmf_checker (.*);
